FILE: design/checked_direct_mapped_score_cache_unit_macros.svh
// Assertion macros used by the checker file.
`ifndef CHECKED_DIRECT_MAPPED_SCORE_CACHE_UNIT_MACROS_SVH
`define CHECKED_DIRECT_MAPPED_SCORE_CACHE_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while reset is asserted.
`define CDMSC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while reset is asserted.
`define CDMSC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/cdmsc_pkg.sv
package cdmsc_pkg;

  localparam int ENTRIES_DEF = 4096;
  localparam int SIDES_DEF   = 2;

  localparam int KEY_W   = 64;
  localparam int SCORE_W = 32;
  localparam int CHK_W   = 32;
  localparam int SLOT_W  = KEY_W + SCORE_W + CHK_W;
  localparam int EU_W    = 13;
  localparam int CFG_AW  = 2;
  localparam int CFG_DW  = 32;

  localparam logic [CHK_W-1:0] CRC_SEED = 32'hFFFF_FFFF;
  localparam logic [CHK_W-1:0] CRC_POLY = 32'h82F6_3B78;

  // Configuration register indexes
  localparam logic [CFG_AW-1:0] REG_ENABLE  = 2'd0;
  localparam logic [CFG_AW-1:0] REG_ENTRIES = 2'd1;
  localparam logic [CFG_AW-1:0] REG_EMPTY   = 2'd2;

  localparam logic [EU_W-1:0]    ENTRIES_RST = 13'd4093;
  localparam logic [SCORE_W-1:0] EMPTY_RST   = 32'hFFFF_8000;

  // Request commands
  localparam logic CMD_PROBE  = 1'b0;
  localparam logic CMD_UPDATE = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic load_req;
    logic clr_start;
    logic clr_wr;
    logic upd_wr;
    logic rd_issue;
    logic crc_load_rd;
    logic probe_eval;
    logic load_out;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_pend;
    logic enable;
    logic is_update;
    logic div_done;
    logic crc_done;
    logic clr_last;
    logic out_free;
  } sts_t;

  // One byte of reflected CRC32C
  function automatic logic [CHK_W-1:0] crc_byte(input logic [CHK_W-1:0] crc,
                                                input logic [7:0] data);
    logic [CHK_W-1:0] c;
    c = crc ^ {24'd0, data};
    for (int b = 0; b < 8; b++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

FILE: design/cdmsc_ram.sv
module cdmsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/cdmsc_dp.sv
module cdmsc_dp #(
  parameter int ENTRIES = cdmsc_pkg::ENTRIES_DEF,
  parameter int SIDES   = cdmsc_pkg::SIDES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [cdmsc_pkg::CFG_AW-1:0]        cfg_addr,
  input  logic [cdmsc_pkg::CFG_DW-1:0]        cfg_wdata,
  input  logic                                in_cmd,
  input  logic                                in_side,
  input  logic [cdmsc_pkg::KEY_W-1:0]         in_key,
  input  logic signed [cdmsc_pkg::SCORE_W-1:0] in_new_score,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic                                out_hit,
  output logic signed [cdmsc_pkg::SCORE_W-1:0] out_cached_score,
  output logic                                out_integrity_error,
  input  cdmsc_pkg::cmd_t                     cmd,
  output cdmsc_pkg::sts_t                     sts
);
  import cdmsc_pkg::*;

  localparam int IW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int MW    = IW + 1;
  localparam int DEPTH = SIDES * ENTRIES;
  localparam int AW    = $clog2(DEPTH);
  localparam int NBYTE = (KEY_W + SCORE_W) / 8;

  // Configuration registers
  logic               enable_r;
  logic [EU_W-1:0]    entries_r;
  logic [SCORE_W-1:0] empty_r;
  logic               clr_pend_r;

  // Request registers
  logic               cmd_r;
  logic               side_r;
  logic [KEY_W-1:0]   key_r;
  logic [SCORE_W-1:0] score_r;

  // Divider, CRC and clear state
  logic [IW-1:0]              rem_r;
  logic [KEY_W-1:0]           kq_r;
  logic [$clog2(KEY_W+1)-1:0] dcnt_r;
  logic [CHK_W-1:0]           crc_r;
  logic [KEY_W+SCORE_W-1:0]   cdata_r;
  logic [$clog2(NBYTE+1)-1:0] bcnt_r;
  logic [AW-1:0]              caddr_r;

  // Result and output registers
  logic               res_hit_r;
  logic [SCORE_W-1:0] res_score_r;
  logic               res_err_r;
  logic               out_valid_r;
  logic               out_hit_r;
  logic [SCORE_W-1:0] out_score_r;
  logic               out_err_r;

  logic [31:0]        eu32;
  logic [MW-1:0]      mod_m;
  logic [MW-1:0]      sh;
  logic [MW-1:0]      rem_nxt;
  logic [AW-1:0]      addr;
  logic               side_sel;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [SLOT_W-1:0]  ram_wdata;
  logic [SLOT_W-1:0]  rd_data;

  // Clamp the modulus to 3..ENTRIES
  always_comb begin
    eu32 = 32'(entries_r);
    if (eu32 < 32'd3) begin
      eu32 = 32'd3;
    end else if (eu32 > 32'(ENTRIES)) begin
      eu32 = 32'(ENTRIES);
    end
    mod_m = MW'(eu32);
  end

  // One restoring remainder step
  always_comb begin
    sh = {rem_r, kq_r[KEY_W-1]};
    rem_nxt = (sh >= mod_m) ? (sh - mod_m) : sh;
  end

  // Slot address: side picks the table
  assign side_sel = (SIDES == 2) ? side_r : 1'b0;
  assign addr = side_sel ? (AW'(ENTRIES) + AW'(rem_r)) : AW'(rem_r);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r   <= 1'b0;
      entries_r  <= ENTRIES_RST;
      empty_r    <= EMPTY_RST;
      clr_pend_r <= 1'b0;
    end else begin
      if (cmd.clr_start) begin
        clr_pend_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_addr)
          REG_ENABLE: begin
            if (cfg_wdata[0] && !enable_r) begin
              clr_pend_r <= 1'b1;
            end
            enable_r <= cfg_wdata[0];
          end
          REG_ENTRIES: entries_r <= cfg_wdata[EU_W-1:0];
          REG_EMPTY:   empty_r   <= cfg_wdata[SCORE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Capture request, set up clear, run divider and CRC
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dcnt_r <= '0;
      bcnt_r <= '0;
    end else begin
      if (cmd.load_req) begin
        cmd_r   <= in_cmd;
        side_r  <= in_side;
        key_r   <= in_key;
        score_r <= in_new_score;
        rem_r   <= '0;
        kq_r    <= in_key;
        dcnt_r  <= ($clog2(KEY_W+1))'(KEY_W);
        crc_r   <= CRC_SEED;
        cdata_r <= {in_new_score, in_key};
        bcnt_r  <= ($clog2(NBYTE+1))'(NBYTE);
      end else if (cmd.clr_start) begin
        key_r   <= '0;
        score_r <= empty_r;
        caddr_r <= '0;
        crc_r   <= CRC_SEED;
        cdata_r <= {empty_r, {KEY_W{1'b0}}};
        bcnt_r  <= ($clog2(NBYTE+1))'(NBYTE);
      end else if (cmd.crc_load_rd) begin
        crc_r   <= CRC_SEED;
        cdata_r <= rd_data[KEY_W+SCORE_W-1:0];
        bcnt_r  <= ($clog2(NBYTE+1))'(NBYTE);
      end else begin
        if (dcnt_r != '0) begin
          rem_r  <= rem_nxt[IW-1:0];
          kq_r   <= kq_r << 1;
          dcnt_r <= dcnt_r - 1'b1;
        end
        if (bcnt_r != '0) begin
          crc_r   <= crc_byte(crc_r, cdata_r[7:0]);
          cdata_r <= cdata_r >> 8;
          bcnt_r  <= bcnt_r - 1'b1;
        end
        if (cmd.clr_wr) begin
          caddr_r <= caddr_r + 1'b1;
        end
      end
    end
  end

  // Store writes for clear and update
  assign ram_we    = cmd.clr_wr | cmd.upd_wr;
  assign ram_waddr = cmd.clr_wr ? caddr_r : addr;
  assign ram_wdata = {~crc_r, score_r, key_r};

  cdmsc_ram #(
    .WIDTH(SLOT_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (cmd.rd_issue),
    .raddr(addr),
    .rdata(rd_data)
  );

  // Build the result
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      res_hit_r   <= 1'b0;
      res_score_r <= '0;
      res_err_r   <= 1'b0;
    end else if (cmd.probe_eval) begin
      if (~crc_r != rd_data[SLOT_W-1 -: CHK_W]) begin
        res_err_r <= 1'b1;
      end else if (rd_data[KEY_W-1:0] == key_r) begin
        res_hit_r   <= 1'b1;
        res_score_r <= rd_data[KEY_W +: SCORE_W];
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
      out_hit_r   <= res_hit_r;
      out_score_r <= res_score_r;
      out_err_r   <= res_err_r;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_hit             = out_hit_r;
  assign out_cached_score    = out_score_r;
  assign out_integrity_error = out_err_r;

  assign sts.clr_pend  = clr_pend_r;
  assign sts.enable    = enable_r;
  assign sts.is_update = (cmd_r == CMD_UPDATE);
  assign sts.div_done  = (dcnt_r == '0);
  assign sts.crc_done  = (bcnt_r == '0);
  assign sts.clr_last  = (caddr_r == AW'(DEPTH - 1));
  assign sts.out_free  = !out_valid_r || out_ready;

endmodule

FILE: design/cdmsc_ctrl.sv
module cdmsc_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  cdmsc_pkg::sts_t sts,
  output cdmsc_pkg::cmd_t cmd
);
  import cdmsc_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CLRCRC = 3'd1;
  localparam logic [2:0] S_CLR    = 3'd2;
  localparam logic [2:0] S_DIV    = 3'd3;
  localparam logic [2:0] S_RDW    = 3'd4;
  localparam logic [2:0] S_CHK    = 3'd5;
  localparam logic [2:0] S_RES    = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Sequence one request or one clear sweep
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = !sts.clr_pend;
        if (sts.clr_pend) begin
          cmd.clr_start = 1'b1;
          state_nxt = S_CLRCRC;
        end else if (in_valid) begin
          cmd.load_req = 1'b1;
          state_nxt = sts.enable ? S_DIV : S_RES;
        end
      end
      S_CLRCRC: begin
        if (sts.clr_pend) begin
          cmd.clr_start = 1'b1;
        end else if (sts.crc_done) begin
          state_nxt = S_CLR;
        end
      end
      S_CLR: begin
        if (sts.clr_pend) begin
          cmd.clr_start = 1'b1;
          state_nxt = S_CLRCRC;
        end else begin
          cmd.clr_wr = 1'b1;
          if (sts.clr_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_DIV: begin
        if (sts.div_done && sts.crc_done) begin
          if (sts.is_update) begin
            cmd.upd_wr = 1'b1;
            state_nxt = S_RES;
          end else begin
            cmd.rd_issue = 1'b1;
            state_nxt = S_RDW;
          end
        end
      end
      S_RDW: begin
        cmd.crc_load_rd = 1'b1;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (sts.crc_done) begin
          cmd.probe_eval = 1'b1;
          state_nxt = S_RES;
        end
      end
      S_RES: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

FILE: design/checked_direct_mapped_score_cache_unit.sv
// One request at a time. Each request runs a 64-step serial remainder unit
// alongside a 12-step byte-wide CRC32C unit; a probe then reruns the CRC
// over the slot it read. With the cache disabled both units are skipped.
// Reset (synchronous, rst_n low) restores registers; the store is swept on
// each enable, with requests held off.
module checked_direct_mapped_score_cache_unit #(
  parameter int ENTRIES = cdmsc_pkg::ENTRIES_DEF,
  parameter int SIDES   = cdmsc_pkg::SIDES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [cdmsc_pkg::CFG_AW-1:0]         cfg_addr,
  input  logic [cdmsc_pkg::CFG_DW-1:0]         cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_cmd,
  input  logic                                 in_side,
  input  logic [cdmsc_pkg::KEY_W-1:0]          in_key,
  input  logic signed [cdmsc_pkg::SCORE_W-1:0] in_new_score,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_hit,
  output logic signed [cdmsc_pkg::SCORE_W-1:0] out_cached_score,
  output logic                                 out_integrity_error
);
  import cdmsc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  cdmsc_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  cdmsc_dp #(
    .ENTRIES(ENTRIES),
    .SIDES  (SIDES)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_addr           (cfg_addr),
    .cfg_wdata          (cfg_wdata),
    .in_cmd             (in_cmd),
    .in_side            (in_side),
    .in_key             (in_key),
    .in_new_score       (in_new_score),
    .out_ready          (out_ready),
    .out_valid          (out_valid),
    .out_hit            (out_hit),
    .out_cached_score   (out_cached_score),
    .out_integrity_error(out_integrity_error),
    .cmd                (cmd),
    .sts                (sts)
  );

endmodule

FILE: design/cdmsc_checker.sv
`include "checked_direct_mapped_score_cache_unit_macros.svh"

module cdmsc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_hit,
  input logic [31:0] out_cached_score,
  input logic        out_integrity_error
);

  // Hold a stalled result
  `CDMSC_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_cached_score), "stalled result changed")

  // A hit never comes with an integrity error
  `CDMSC_ASSERT_IMP(a_hit_err, out_valid && out_hit, !out_integrity_error, "hit with integrity error")

  // A miss reports a zero score
  `CDMSC_ASSERT_IMP(a_miss_zero, out_valid && !out_hit, out_cached_score == 32'd0, "miss with nonzero score")

  // One request in flight: no accept right after an accept
  `CDMSC_ASSERT_NXT(a_one_req, in_valid && in_ready, !in_ready, "request accepted while busy")

endmodule

bind checked_direct_mapped_score_cache_unit cdmsc_checker u_cdmsc_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_hit            (out_hit),
  .out_cached_score   (out_cached_score),
  .out_integrity_error(out_integrity_error)
);
